>>> hw/rtl/sha256_pkg.sv
// shared types, round constants and mixing functions for the sha-256 hasher
`timescale 1ns / 1ps

package sha256_pkg;

	localparam int FILL_W = 6;
	localparam int LEN_W = 61;
	localparam int RND_W = 6;
	localparam int WIDX_W = 3;

	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] FILL_LEN_AT = 6'd56;
	localparam logic [RND_W-1:0] RND_LAST = 6'd63;
	localparam logic [WIDX_W-1:0] WIDX_LAST = 3'd7;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_PAD_ONE  = 7'b0000010,
		ST_PAD_ZERO = 7'b0000100,
		ST_PAD_LEN  = 7'b0001000,
		ST_ROUND    = 7'b0010000,
		ST_FINAL    = 7'b0100000,
		ST_OUT      = 7'b1000000
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	typedef struct packed {
		logic              push;
		byte_src_t         src;
		logic              count_len;
		logic              start;
		logic              round;
		logic              add_hash;
		logic              clear_msg;
		logic [WIDX_W-1:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              round_last;
	} dp_status_t;

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

>>> hw/rtl/sha256_dp.sv
// datapath: block shift register, message schedule, round unit, hash words and length
`timescale 1ns / 1ps

module sha256_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::dp_cmd_t  cmd,
	input  logic [7:0]           data_byte,
	output sha256_pkg::dp_status_t stat,
	output logic [31:0]          digest
);

	logic [511:0]                      blk_q;
	logic [sha256_pkg::FILL_W-1:0]     fill_q;
	logic [sha256_pkg::LEN_W-1:0]      len_q;
	logic [sha256_pkg::RND_W-1:0]      rnd_q;
	logic [31:0]                       hash_q [8];
	logic [31:0]                       v_q [8];

	logic [63:0]  bit_len;
	logic [5:0]   len_lsb;
	logic [7:0]   push_byte;
	logic [31:0]  w_cur;
	logic [31:0]  w_new;
	logic [31:0]  t1;
	logic [31:0]  t2;

	assign bit_len = {len_q, 3'b000};
	assign len_lsb = {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.src)
			sha256_pkg::SRC_DATA: push_byte = data_byte;
			sha256_pkg::SRC_PAD:  push_byte = sha256_pkg::PAD_BYTE;
			sha256_pkg::SRC_ZERO: push_byte = 8'h00;
			sha256_pkg::SRC_LEN:  push_byte = bit_len[len_lsb +: 8];
			default:              push_byte = 8'h00;
		endcase
	end

	// window word k sits at blk_q[511-32k -: 32]
	assign w_cur = blk_q[511:480];
	assign w_new = sha256_pkg::small_s1(blk_q[63:32]) + blk_q[223:192]
		+ sha256_pkg::small_s0(blk_q[479:448]) + w_cur;

	assign t1 = v_q[7] + sha256_pkg::big_s1(v_q[4])
		+ sha256_pkg::choose(v_q[4], v_q[5], v_q[6])
		+ sha256_pkg::ROUND_K[rnd_q] + w_cur;
	assign t2 = sha256_pkg::big_s0(v_q[0]) + sha256_pkg::majority(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha256_pkg::INIT_HASH[i];
			end
		end else begin
			if (cmd.clear_msg) begin
				fill_q <= '0;
			end else if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.clear_msg) begin
				len_q <= '0;
			end else if (cmd.count_len) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (cmd.clear_msg) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= sha256_pkg::INIT_HASH[i];
				end
			end else if (cmd.add_hash) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	assign stat.fill       = fill_q;
	assign stat.round_last = (rnd_q == sha256_pkg::RND_LAST);
	assign digest          = hash_q[cmd.word_idx];

endmodule

>>> hw/rtl/sha256_ctrl.sv
// controller: byte intake, padding sequence, round count and digest output
`timescale 1ns / 1ps

module sha256_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sha256_pkg::WIDX_W-1:0]     m_tuser,
	output logic                              m_tlast,
	input  sha256_pkg::dp_status_t            stat,
	output sha256_pkg::dp_cmd_t               cmd
);

	sha256_pkg::ctrl_state_t           state_q;
	sha256_pkg::ctrl_state_t           state_d;
	sha256_pkg::ctrl_state_t           resume_q;
	sha256_pkg::ctrl_state_t           resume_d;
	logic [sha256_pkg::WIDX_W-1:0]     widx_q;
	logic                              block_full;

	assign block_full = (stat.fill == sha256_pkg::FILL_LAST);

	always_comb begin
		cmd          = '0;
		cmd.src      = sha256_pkg::SRC_DATA;
		cmd.word_idx = widx_q;
		state_d      = state_q;
		resume_d     = resume_q;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tlast ? sha256_pkg::ST_PAD_ONE : sha256_pkg::ST_IDLE;
					if (s_tuser) begin
						cmd.push      = 1'b1;
						cmd.count_len = 1'b1;
						if (block_full) begin
							cmd.start = 1'b1;
							resume_d  = state_d;
							state_d   = sha256_pkg::ST_ROUND;
						end
					end
				end
			end
			sha256_pkg::ST_PAD_ONE: begin
				cmd.push = 1'b1;
				cmd.src  = sha256_pkg::SRC_PAD;
				state_d  = sha256_pkg::ST_PAD_ZERO;
				if (block_full) begin
					cmd.start = 1'b1;
					resume_d  = sha256_pkg::ST_PAD_ZERO;
					state_d   = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_PAD_ZERO: begin
				if (stat.fill == sha256_pkg::FILL_LEN_AT) begin
					state_d = sha256_pkg::ST_PAD_LEN;
				end else begin
					cmd.push = 1'b1;
					cmd.src  = sha256_pkg::SRC_ZERO;
					if (block_full) begin
						cmd.start = 1'b1;
						resume_d  = sha256_pkg::ST_PAD_ZERO;
						state_d   = sha256_pkg::ST_ROUND;
					end
				end
			end
			sha256_pkg::ST_PAD_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = sha256_pkg::SRC_LEN;
				if (block_full) begin
					cmd.start = 1'b1;
					resume_d  = sha256_pkg::ST_OUT;
					state_d   = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_last) begin
					state_d = sha256_pkg::ST_FINAL;
				end
			end
			sha256_pkg::ST_FINAL: begin
				cmd.add_hash = 1'b1;
				state_d      = resume_q;
			end
			sha256_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && widx_q == sha256_pkg::WIDX_LAST) begin
					cmd.clear_msg = 1'b1;
					state_d       = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha256_pkg::ST_IDLE;
			resume_q <= sha256_pkg::ST_IDLE;
			widx_q   <= '0;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
			if (m_tvalid && m_tready) begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	assign m_tuser = widx_q;
	assign m_tlast = (widx_q == sha256_pkg::WIDX_LAST);

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// top level of the byte-stream sha-256 hasher
`timescale 1ns / 1ps

// Takes one message byte per beat and returns the 256-bit digest as eight 32-bit beats,
// most significant word first, with tlast on the eighth. A beat with tuser low carries no
// byte; tlast closes the message after any byte in the same beat, and the next message
// starts from the standard initial hash. Bytes are taken one per cycle while a 64-byte
// block fills; each completed block then holds s_tready low while it runs 64 rounds, one
// per cycle in the single round unit, and then folds the result into the hash.
// Closing a message runs the padding one byte per cycle, pausing while a completed block
// runs its rounds: 9 to 72 bytes, plus a step that pushes no byte before the length bytes,
// filling one or two blocks, after which the eight digest beats are offered; new input is
// taken once the last of them has been accepted.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	sha256_pkg::dp_cmd_t    cmd;
	sha256_pkg::dp_status_t stat;

	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha256_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (s_tdata),
		.stat      (stat),
		.digest    (m_tdata)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while digest pending");

	a_pad_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> stat.fill == '0)
		else $error("digest offered with partial block");

	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("end of message did not start padding");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("no return to intake after digest");

endmodule
